[hdl/fasc_pkg.sv]
// Shared widths, register indexes, codes and pipeline control type for the
// frustum and size box cull core. No dependencies.
package fasc_pkg;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int MAT_W    = 32;
    localparam int RATIO_W  = 40;

    // Plane store geometry
    localparam int PLANES   = 6;
    localparam int AXES     = 3;
    localparam int COMP_N   = AXES + 1;
    localparam int BIAS_IDX = AXES;
    localparam int ROWS     = 4;
    localparam int W_ROW    = 3;

    // Plane arithmetic: row 3 plus or minus another row, times a coordinate
    localparam int COEF_W   = MAT_W + 1;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int DIST_W   = PROD_W + 2;

    // Size test arithmetic (doubled values, squared)
    localparam int EXT_W     = COORD_W + 1;
    localparam int EXT_SQ_W  = 2 * COORD_W;
    localparam int RAD_W     = EXT_SQ_W + 2;
    localparam int OFF_W     = COORD_W + 2;
    localparam int OFF_SQ_W  = 2 * COORD_W + 2;
    localparam int DSQ_W     = OFF_SQ_W + 2;
    localparam int RATIO_LO_W = RATIO_W / 2;
    localparam int RATIO_HI_W = RATIO_W - RATIO_LO_W;
    localparam int PART_LO_W = DSQ_W + RATIO_LO_W;
    localparam int PART_HI_W = DSQ_W + RATIO_HI_W;
    localparam int CMP_W     = DSQ_W + RATIO_W;

    // Configuration port
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int ADDR_LSB  = 3;
    localparam int REG_IDX_W = ADDR_W - ADDR_LSB;

    localparam logic [REG_IDX_W-1:0] REG_EYE_X       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EYE_Y       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EYE_Z       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATIO_SQ    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_ENABLE = 3'd4;

    // Request mode
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_BOX  = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_VISIBLE   = 2'd0;
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd1;
    localparam logic [1:0] VERDICT_TOO_SMALL = 2'd2;

    // Stage load enables handed to the plane lanes
    typedef struct packed {
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

endpackage

[hdl/fasc_plane_lane.sv]
// One frustum plane lane: positive vertex products, then signed distance.
// Depends on fasc_pkg.
module fasc_plane_lane (
    input  logic                                  aclk,
    input  fasc_pkg::pipe_ctl_t                   ctl,
    input  logic signed [fasc_pkg::COEF_W-1:0]    coef   [fasc_pkg::COMP_N],
    input  logic signed [fasc_pkg::COORD_W-1:0]   box_lo [fasc_pkg::AXES],
    input  logic signed [fasc_pkg::COORD_W-1:0]   box_hi [fasc_pkg::AXES],
    output logic                                  outside
);
    import fasc_pkg::*;

    logic signed [COORD_W-1:0] vtx       [AXES];
    logic signed [PROD_W-1:0]  prod_next [AXES];
    logic signed [PROD_W-1:0]  prod_reg  [AXES];
    logic signed [COEF_W-1:0]  bias_reg;
    logic signed [DIST_W-1:0]  plane_sum;
    logic                      outside_reg;

    // Pick the positive vertex per axis and multiply
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            vtx[a]       = coef[a][COEF_W-1] ? box_lo[a] : box_hi[a];
            prod_next[a] = coef[a] * vtx[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            prod_reg <= prod_next;
            bias_reg <= coef[BIAS_IDX];
        end
    end

    assign plane_sum = DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1])
                     + DIST_W'(prod_reg[2]) + DIST_W'(bias_reg);

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            outside_reg <= plane_sum[DIST_W-1];
        end
    end

    assign outside = outside_reg;

endmodule

[hdl/frustum_and_size_box_cull_core.sv]
// Top level of the frustum and screen-size box cull core.
// Depends on fasc_pkg and fasc_plane_lane.
//
// Usage:
//   Input channel (s_valid/s_ready): each request is either a matrix column
//   load (s_mode = 0) or a box test (s_mode = 1). A load writes column
//   s_column_index of all six frustum planes (row 3 plus/minus rows 0..2) and
//   returns nothing. A box test returns one verdict on the m_ channel:
//   0 visible, 1 outside the frustum, 2 too small on screen.
//   Config port (APB style, 64-bit data, registers at 8*index): eye x/y/z,
//   size_ratio_squared (Q0.40) and size_test_enable. Write only while idle.
//   Path: a box passes the input, product, sum, ratio-product and output
//   registers before its verdict shows on m_. Throughput: one request per
//   cycle while m_ready is high; eighteen plane multipliers and the two split
//   ratio multipliers each have their own stage, so nothing is shared.
//   A box accepted right after a load sees the new column: loads commit to
//   the plane store as they leave the input register.
//   Reset (aresetn low, synchronous): planes and config clear to zero, so
//   every box is visible until columns are loaded; all valid bits clear.
//   Stall: each stage holds while the one after it is full and blocked, so
//   bubbles collapse and s_ready stays high while a verdict waits on m_ready
//   as long as some stage is empty.
module frustum_and_size_box_cull_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input requests
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic [1:0]                            s_column_index,
    input  logic signed [fasc_pkg::MAT_W-1:0]     s_matrix_row0_entry,
    input  logic signed [fasc_pkg::MAT_W-1:0]     s_matrix_row1_entry,
    input  logic signed [fasc_pkg::MAT_W-1:0]     s_matrix_row2_entry,
    input  logic signed [fasc_pkg::MAT_W-1:0]     s_matrix_row3_entry,
    input  logic signed [fasc_pkg::COORD_W-1:0]   s_box_min_x,
    input  logic signed [fasc_pkg::COORD_W-1:0]   s_box_min_y,
    input  logic signed [fasc_pkg::COORD_W-1:0]   s_box_min_z,
    input  logic signed [fasc_pkg::COORD_W-1:0]   s_box_max_x,
    input  logic signed [fasc_pkg::COORD_W-1:0]   s_box_max_y,
    input  logic signed [fasc_pkg::COORD_W-1:0]   s_box_max_z,
    // Verdicts
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_verdict,
    // Configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fasc_pkg::ADDR_W-1:0]           paddr,
    input  logic [fasc_pkg::DATA_W-1:0]           pwdata,
    output logic [fasc_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import fasc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] eye_reg [AXES];
    logic [RATIO_W-1:0]        ratio_sq_reg;
    logic                      size_test_enable_reg;
    logic                      cfg_write;
    logic [REG_IDX_W-1:0]      cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[ADDR_W-1:ADDR_LSB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                eye_reg[a] <= '0;
            end
            ratio_sq_reg         <= '0;
            size_test_enable_reg <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_EYE_X:       eye_reg[0] <= pwdata[COORD_W-1:0];
                REG_EYE_Y:       eye_reg[1] <= pwdata[COORD_W-1:0];
                REG_EYE_Z:       eye_reg[2] <= pwdata[COORD_W-1:0];
                REG_RATIO_SQ:    ratio_sq_reg <= pwdata[RATIO_W-1:0];
                REG_SIZE_ENABLE: size_test_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_EYE_X:       prdata = {{(DATA_W-COORD_W){1'b0}}, eye_reg[0]};
            REG_EYE_Y:       prdata = {{(DATA_W-COORD_W){1'b0}}, eye_reg[1]};
            REG_EYE_Z:       prdata = {{(DATA_W-COORD_W){1'b0}}, eye_reg[2]};
            REG_RATIO_SQ:    prdata = {{(DATA_W-RATIO_W){1'b0}}, ratio_sq_reg};
            REG_SIZE_ENABLE: prdata = {{(DATA_W-1){1'b0}}, size_test_enable_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic en1, en2, en3, en4, en_out;
    pipe_ctl_t lane_ctl;

    assign en_out  = !m_valid_reg || m_ready;
    assign en4     = !v4_reg || en_out;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign lane_ctl.ld2 = en2;
    assign lane_ctl.ld3 = en3;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                      mode1_reg;
    logic [1:0]                col1_reg;
    logic signed [MAT_W-1:0]   row1_reg [ROWS];
    logic signed [COORD_W-1:0] lo1_reg  [AXES];
    logic signed [COORD_W-1:0] hi1_reg  [AXES];

    always_ff @(posedge aclk) begin
        if (en1) begin
            mode1_reg   <= s_mode;
            col1_reg    <= s_column_index;
            row1_reg[0] <= s_matrix_row0_entry;
            row1_reg[1] <= s_matrix_row1_entry;
            row1_reg[2] <= s_matrix_row2_entry;
            row1_reg[3] <= s_matrix_row3_entry;
            lo1_reg[0]  <= s_box_min_x;
            lo1_reg[1]  <= s_box_min_y;
            lo1_reg[2]  <= s_box_min_z;
            hi1_reg[0]  <= s_box_max_x;
            hi1_reg[1]  <= s_box_max_y;
            hi1_reg[2]  <= s_box_max_z;
        end
    end

    // ------------------------------------------------------------------
    // Plane store: commit a column load as it leaves stage 1
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] plane_reg  [PLANES][COMP_N];
    logic signed [COEF_W-1:0] load_value [PLANES];
    logic                     plane_write;

    always_comb begin
        for (int r = 0; r < W_ROW; r++) begin
            load_value[2*r]   = COEF_W'(row1_reg[W_ROW]) + COEF_W'(row1_reg[r]);
            load_value[2*r+1] = COEF_W'(row1_reg[W_ROW]) - COEF_W'(row1_reg[r]);
        end
    end

    assign plane_write = v1_reg && (mode1_reg == MODE_LOAD) && en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PLANES; p++) begin
                for (int c = 0; c < COMP_N; c++) begin
                    plane_reg[p][c] <= '0;
                end
            end
        end else if (plane_write) begin
            for (int p = 0; p < PLANES; p++) begin
                plane_reg[p][col1_reg] <= load_value[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Plane lanes: stage 2 products, stage 3 distance sign
    // ------------------------------------------------------------------
    logic [PLANES-1:0] lane_outside;

    for (genvar p = 0; p < PLANES; p++) begin : g_lane
        fasc_plane_lane u_lane (
            .aclk    (aclk),
            .ctl     (lane_ctl),
            .coef    (plane_reg[p]),
            .box_lo  (lo1_reg),
            .box_hi  (hi1_reg),
            .outside (lane_outside[p])
        );
    end

    // ------------------------------------------------------------------
    // Size test, stage 2: squared extent and squared doubled center offset
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0]     ext      [AXES];
    logic signed [OFF_W-1:0]     off      [AXES];
    logic signed [2*EXT_W-1:0]   ext_full [AXES];
    logic signed [2*OFF_W-1:0]   off_full [AXES];
    logic [EXT_SQ_W-1:0]         ext_sq2_reg [AXES];
    logic [OFF_SQ_W-1:0]         off_sq2_reg [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            ext[a]      = EXT_W'(hi1_reg[a]) - EXT_W'(lo1_reg[a]);
            off[a]      = OFF_W'(lo1_reg[a]) + OFF_W'(hi1_reg[a])
                        - (OFF_W'(eye_reg[a]) <<< 1);
            ext_full[a] = ext[a] * ext[a];
            off_full[a] = off[a] * off[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int a = 0; a < AXES; a++) begin
                ext_sq2_reg[a] <= ext_full[a][EXT_SQ_W-1:0];
                off_sq2_reg[a] <= off_full[a][OFF_SQ_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: radius and distance sums
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] rad3_reg;
    logic [DSQ_W-1:0] dist3_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            rad3_reg  <= RAD_W'(ext_sq2_reg[0]) + RAD_W'(ext_sq2_reg[1])
                       + RAD_W'(ext_sq2_reg[2]);
            dist3_reg <= DSQ_W'(off_sq2_reg[0]) + DSQ_W'(off_sq2_reg[1])
                       + DSQ_W'(off_sq2_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: frustum OR, distance compare, split ratio products
    // ------------------------------------------------------------------
    logic                 outside4_reg;
    logic                 far4_reg;
    logic [RAD_W-1:0]     rad4_reg;
    logic [PART_LO_W-1:0] part_lo4_reg;
    logic [PART_HI_W-1:0] part_hi4_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            outside4_reg <= |lane_outside;
            far4_reg     <= DSQ_W'(rad3_reg) < dist3_reg;
            rad4_reg     <= rad3_reg;
            part_lo4_reg <= PART_LO_W'(dist3_reg) * PART_LO_W'(ratio_sq_reg[RATIO_LO_W-1:0]);
            part_hi4_reg <= PART_HI_W'(dist3_reg)
                          * PART_HI_W'(ratio_sq_reg[RATIO_W-1:RATIO_LO_W]);
        end
    end

    // ------------------------------------------------------------------
    // Output register: assemble ratio product, compare, pick verdict
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] ratio_prod;
    logic [CMP_W-1:0] rad_scaled;
    logic             too_small;
    logic [1:0]       m_verdict_reg;
    logic [1:0]       m_verdict_next;

    assign ratio_prod = CMP_W'(part_lo4_reg) + (CMP_W'(part_hi4_reg) << RATIO_LO_W);
    assign rad_scaled = CMP_W'(rad4_reg) << RATIO_W;
    assign too_small  = size_test_enable_reg && far4_reg && (rad_scaled < ratio_prod);

    always_comb begin
        if (outside4_reg) begin
            m_verdict_next = VERDICT_OUTSIDE;
        end else if (too_small) begin
            m_verdict_next = VERDICT_TOO_SMALL;
        end else begin
            m_verdict_next = VERDICT_VISIBLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_verdict_reg <= m_verdict_next;
        end
    end

    // Valid bits: loads retire in stage 1, only boxes move on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg      <= s_valid;
            if (en2)    v2_reg      <= v1_reg && (mode1_reg == MODE_BOX);
            if (en3)    v3_reg      <= v2_reg;
            if (en4)    v4_reg      <= v3_reg;
            if (en_out) m_valid_reg <= v4_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_outside_wins: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && en_out && outside4_reg) |=> (m_verdict_reg == VERDICT_OUTSIDE))
        else $error("outside box did not report outside");

    a_size_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && en_out && !size_test_enable_reg) |=>
            (m_verdict_reg != VERDICT_TOO_SMALL))
        else $error("too-small verdict with size test disabled");

    a_result_from_s4: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v4_reg))
        else $error("verdict appeared without a box in stage 4");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        plane_write |=> !v2_reg)
        else $error("column load advanced past stage 1");

endmodule
